// File: sv/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants for the button debounce and long-press block
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int PORT_W  = 8;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int OUT_W   = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

	typedef enum logic [1:0] {
		REG_DEBOUNCE_TIME     = 2'd0,
		REG_LONG_PRESS_TIME   = 2'd1,
		REG_LONG_PRESS_ENABLE = 2'd2,
		REG_UNUSED            = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] long_press_time;
		logic             long_press_enable;
	} cfg_t;

	typedef struct packed {
		logic press_event;
		logic long_event;
		logic pressed;
	} lane_res_t;

endpackage

// File: sv/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press
// debounce with time lockout and long-press detection, one lane per button
// ----------------------------------------------------------------------------
// channel  dir  contents
// s_axis   in   tdata[7:0] port_sample, tdata[39:8] time_ms
// m_axis   out  tdata[4:0] press_events, [9:5] long_press_events,
//               [14:10] debounced_mask, [15] zero
// cfg      in   cfg_we, cfg_index, cfg_data
//
// one sample per cycle unless the output stalls; every lane updates its state
// in the transfer cycle; a result appears in the cycle after its input transfer
// a waiting result does not block input when m_tready is high in that cycle
// reset clears the lane state and loads the register defaults
// ----------------------------------------------------------------------------
module button_debounce_long_press #(
	parameter int BUTTON_COUNT = 5,
	parameter int FIRST_PIN    = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bdlp_pkg::IN_TDATA_W-1:0]     s_tdata,  // port_sample, time_ms
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bdlp_pkg::OUT_TDATA_W-1:0]    m_tdata,  // press, long press, debounced
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [bdlp_pkg::CFG_W-1:0]          cfg_data
);

	bdlp_pkg::cfg_t      cfg_q;
	bdlp_pkg::lane_res_t lanes [BUTTON_COUNT];
	logic                accept;
	logic [bdlp_pkg::PORT_W-1:0] port_sample;
	logic [bdlp_pkg::TIME_W-1:0] time_ms;

	assign port_sample = s_tdata[bdlp_pkg::PORT_W-1:0];
	assign time_ms     = s_tdata[bdlp_pkg::PORT_W +: bdlp_pkg::TIME_W];
	assign s_tready    = !m_tvalid || m_tready;
	assign accept      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time     <= bdlp_pkg::DEBOUNCE_RESET;
			cfg_q.long_press_time   <= bdlp_pkg::LONG_PRESS_RESET;
			cfg_q.long_press_enable <= 1'b0;
		end else if (cfg_we) begin
			case (bdlp_pkg::cfg_reg_t'(cfg_index))
				bdlp_pkg::REG_DEBOUNCE_TIME:     cfg_q.debounce_time     <= cfg_data;
				bdlp_pkg::REG_LONG_PRESS_TIME:   cfg_q.long_press_time   <= cfg_data;
				bdlp_pkg::REG_LONG_PRESS_ENABLE: cfg_q.long_press_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
		localparam int PIN = FIRST_PIN + g;
		logic level;
		if (PIN < bdlp_pkg::PORT_W) begin : g_pin
			assign level = !port_sample[PIN];
		end else begin : g_nopin
			assign level = 1'b0;
		end
		bdlp_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.accept    (accept),
			.raw_level (level),
			.now       (time_ms),
			.cfg       (cfg_q),
			.res       (lanes[g])
		);
	end

	bdlp_merge #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.lanes    (lanes),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

// File: sv/bdlp_lane.sv
// ----------------------------------------------------------------------------
// bdlp_lane
// per-button debounce lockout and long-press detection
// ----------------------------------------------------------------------------
module bdlp_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              raw_level,
	input  logic [bdlp_pkg::TIME_W-1:0]       now,
	input  bdlp_pkg::cfg_t                    cfg,
	output bdlp_pkg::lane_res_t               res
);

	logic [bdlp_pkg::TIME_W-1:0] last_change_q;
	logic [bdlp_pkg::TIME_W-1:0] press_start_q;
	logic                        pressed_q;
	logic                        fired_q;

	logic [bdlp_pkg::TIME_W-1:0] since_change;
	logic [bdlp_pkg::TIME_W-1:0] since_press;
	logic                        change;
	logic                        take_change;
	logic                        fire;

	assign since_change = now - last_change_q;
	assign since_press  = now - press_start_q;
	assign change       = raw_level != pressed_q;
	assign take_change  = change && (since_change >=
		{{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_W){1'b0}}, cfg.debounce_time});
	assign fire         = !change && pressed_q && cfg.long_press_enable && !fired_q &&
		(since_press >= {{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_W){1'b0}}, cfg.long_press_time});

	always_comb begin
		res.press_event = take_change && raw_level;
		res.long_event  = fire;
		res.pressed     = take_change ? raw_level : pressed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_change_q <= '0;
			press_start_q <= '0;
			pressed_q     <= 1'b0;
			fired_q       <= 1'b0;
		end else if (accept) begin
			if (take_change) begin
				last_change_q <= now;
				pressed_q     <= raw_level;
				if (raw_level) begin
					press_start_q <= now;
					fired_q       <= 1'b0;
				end
			end else if (fire) begin
				fired_q <= 1'b1;
			end
		end
	end

endmodule

// File: sv/bdlp_merge.sv
// ----------------------------------------------------------------------------
// bdlp_merge
// gathers lane results into the event masks and holds the output register
// ----------------------------------------------------------------------------
module bdlp_merge #(
	parameter int BUTTON_COUNT = 5
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  bdlp_pkg::lane_res_t                    lanes [BUTTON_COUNT],
	input  logic                                   m_tready,
	output logic                                   m_tvalid,
	output logic [bdlp_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	logic [bdlp_pkg::OUT_W-1:0] press_mask;
	logic [bdlp_pkg::OUT_W-1:0] long_mask;
	logic [bdlp_pkg::OUT_W-1:0] deb_mask;
	logic                       valid_q;
	logic [bdlp_pkg::OUT_TDATA_W-1:0] data_q;

	for (genvar g = 0; g < bdlp_pkg::OUT_W; g++) begin : g_bit
		if (g < BUTTON_COUNT) begin : g_lane
			assign press_mask[g] = lanes[g].press_event;
			assign long_mask[g]  = lanes[g].long_event;
			assign deb_mask[g]   = lanes[g].pressed;
		end else begin : g_none
			assign press_mask[g] = 1'b0;
			assign long_mask[g]  = 1'b0;
			assign deb_mask[g]   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= {1'b0, deb_mask, long_mask, press_mask};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule
